/* sv/fdp_pkg.sv */
// ----------------------------------------------------------------------------
// Form data pair parser package
// Shared types, codes and constants for the form record pair parser.
// ----------------------------------------------------------------------------
package fdp_pkg;

   localparam int unsigned KeyBytes   = 8;
   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

   // Result kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_PAIR  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_KEYS  = 2'd0;
   localparam logic [1:0] CSR_MAX_BYTES = 2'd1;

   // Special characters
   localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
   localparam logic [7:0] CHAR_SEMI    = 8'h3B;
   localparam logic [7:0] CHAR_AMP     = 8'h26;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;

   typedef enum logic [4:0] {
      MODE_KEY   = 5'b00001,
      MODE_VALUE = 5'b00010,
      MODE_HEX1  = 5'b00100,
      MODE_HEX2  = 5'b01000,
      MODE_SKIP  = 5'b10000
   } mode_type;

   // One classified record byte, as it travels through the queue
   typedef struct packed {
      logic [7:0] data;
      logic [3:0] hex;
      logic       is_zero;
      logic       is_equals;
      logic       is_sep;
      logic       is_percent;
      logic       is_plus;
   } class_type;

   typedef struct packed {
      logic [8:0]  max_keys;
      logic [15:0] max_bytes;
   } cfg_type;

   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = 4'(c - 8'h37);
      end
      return v;
   endfunction

endpackage

/* sv/fdp_front.sv */
// ----------------------------------------------------------------------------
// Form data pair parser front end
// Classify incoming bytes and hold them in a short queue for the back end.
// ----------------------------------------------------------------------------
module fdp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   output logic                q_valid,
   output fdp_pkg::class_type  q_head,
   input  logic                q_pop
);

   fdp_pkg::class_type                 cls;
   fdp_pkg::class_type                 entry_ff [fdp_pkg::QueueDepth];
   logic [fdp_pkg::QueuePtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [fdp_pkg::QueuePtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [fdp_pkg::QueuePtrW:0]        count_ff, count_in;
   logic                               push;
   logic                               pop;

   always_comb begin
      cls.data       = req_data_byte;
      cls.hex        = fdp_pkg::hex_value(req_data_byte);
      cls.is_zero    = (req_data_byte == 8'd0);
      cls.is_equals  = (req_data_byte == fdp_pkg::CHAR_EQUALS);
      cls.is_sep     = (req_data_byte == fdp_pkg::CHAR_SEMI) ||
                       (req_data_byte == fdp_pkg::CHAR_AMP);
      cls.is_percent = (req_data_byte == fdp_pkg::CHAR_PERCENT);
      cls.is_plus    = (req_data_byte == fdp_pkg::CHAR_PLUS);
   end

   assign req_ready = (count_ff != (fdp_pkg::QueuePtrW+1)'(fdp_pkg::QueueDepth));
   assign push      = req_valid && req_ready;
   assign q_valid   = (count_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule

/* sv/fdp_back.sv */
// ----------------------------------------------------------------------------
// Form data pair parser back end
// Run the record state machine on queued bytes and register one result.
// ----------------------------------------------------------------------------
module fdp_back (
   input  logic                clock,
   input  logic                reset,
   input  fdp_pkg::cfg_type    cfg,
   input  logic                q_valid,
   input  fdp_pkg::class_type  q_head,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_item_kind,
   output logic [7:0]          rsp_value_byte,
   output logic [63:0]         rsp_packed_key,
   output logic [7:0]          rsp_pair_index
);

   fdp_pkg::mode_type mode_ff, mode_in;
   logic [63:0] key_ff, key_in;
   logic [3:0]  key_pos_ff, key_pos_in;
   logic [3:0]  nibble_ff, nibble_in;
   logic [8:0]  pair_cnt_ff, pair_cnt_in;
   logic [15:0] byte_cnt_ff, byte_cnt_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  vbyte_ff, vbyte_in;
   logic [63:0] pkey_ff, pkey_in;
   logic [7:0]  pidx_ff, pidx_in;

   logic        advance;
   logic        res;
   logic [8:0]  next_pair;
   logic        key_limit;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign q_pop     = advance && q_valid;
   assign next_pair = pair_cnt_ff + 9'd1;
   assign key_limit = (next_pair >= cfg.max_keys);

   always_comb begin
      mode_in     = mode_ff;
      key_in      = key_ff;
      key_pos_in  = key_pos_ff;
      nibble_in   = nibble_ff;
      pair_cnt_in = pair_cnt_ff;
      byte_cnt_in = byte_cnt_ff;
      res         = 1'b0;
      kind_in     = fdp_pkg::KIND_BYTE;
      vbyte_in    = 8'd0;
      pkey_in     = 64'd0;
      pidx_in     = 8'd0;

      if (q_head.is_zero) begin
         // record end: close an open pair, then clear everything
         if (mode_ff == fdp_pkg::MODE_VALUE || mode_ff == fdp_pkg::MODE_HEX1 ||
             mode_ff == fdp_pkg::MODE_HEX2) begin
            res = 1'b1;
            if (key_limit) begin
               kind_in = fdp_pkg::KIND_ERROR;
            end else begin
               kind_in = fdp_pkg::KIND_PAIR;
               pkey_in = key_ff;
               pidx_in = pair_cnt_ff[7:0];
            end
         end
         mode_in     = fdp_pkg::MODE_KEY;
         key_in      = 64'd0;
         key_pos_in  = 4'd0;
         nibble_in   = 4'd0;
         pair_cnt_in = 9'd0;
         byte_cnt_in = 16'd0;
      end else if (mode_ff == fdp_pkg::MODE_SKIP) begin
         // drop until record end
      end else if (byte_cnt_ff >= cfg.max_bytes) begin
         res     = 1'b1;
         kind_in = fdp_pkg::KIND_ERROR;
         mode_in = fdp_pkg::MODE_SKIP;
      end else begin
         byte_cnt_in = byte_cnt_ff + 16'd1;
         unique case (mode_ff)
            fdp_pkg::MODE_KEY: begin
               if (q_head.is_equals) begin
                  key_pos_in = 4'(fdp_pkg::KeyBytes);
                  mode_in    = fdp_pkg::MODE_VALUE;
               end else if (key_pos_ff < 4'(fdp_pkg::KeyBytes)) begin
                  key_in[{key_pos_ff[2:0], 3'b000} +: 8] = q_head.data;
                  key_pos_in = key_pos_ff + 4'd1;
               end
            end
            fdp_pkg::MODE_VALUE: begin
               if (q_head.is_sep) begin
                  res = 1'b1;
                  if (key_limit) begin
                     kind_in = fdp_pkg::KIND_ERROR;
                     mode_in = fdp_pkg::MODE_SKIP;
                  end else begin
                     kind_in     = fdp_pkg::KIND_PAIR;
                     pkey_in     = key_ff;
                     pidx_in     = pair_cnt_ff[7:0];
                     pair_cnt_in = next_pair;
                     mode_in     = fdp_pkg::MODE_KEY;
                     key_in      = 64'd0;
                     key_pos_in  = 4'd0;
                  end
               end else if (q_head.is_percent) begin
                  mode_in = fdp_pkg::MODE_HEX1;
               end else begin
                  res      = 1'b1;
                  vbyte_in = q_head.is_plus ? fdp_pkg::CHAR_SPACE : q_head.data;
               end
            end
            fdp_pkg::MODE_HEX1: begin
               nibble_in = q_head.hex;
               mode_in   = fdp_pkg::MODE_HEX2;
            end
            fdp_pkg::MODE_HEX2: begin
               res       = 1'b1;
               vbyte_in  = {nibble_ff, q_head.hex};
               nibble_in = 4'd0;
               mode_in   = fdp_pkg::MODE_VALUE;
            end
            default: begin
               mode_in = fdp_pkg::MODE_SKIP;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = q_valid && res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= fdp_pkg::MODE_KEY;
         key_ff       <= 64'd0;
         key_pos_ff   <= 4'd0;
         nibble_ff    <= 4'd0;
         pair_cnt_ff  <= 9'd0;
         byte_cnt_ff  <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (q_pop) begin
            mode_ff     <= mode_in;
            key_ff      <= key_in;
            key_pos_ff  <= key_pos_in;
            nibble_ff   <= nibble_in;
            pair_cnt_ff <= pair_cnt_in;
            byte_cnt_ff <= byte_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && res) begin
         kind_ff  <= kind_in;
         vbyte_ff <= vbyte_in;
         pkey_ff  <= pkey_in;
         pidx_ff  <= pidx_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_item_kind  = kind_ff;
   assign rsp_value_byte = vbyte_ff;
   assign rsp_packed_key = pkey_ff;
   assign rsp_pair_index = pidx_ff;

endmodule

/* sv/form_data_pair_parser.sv */
// ----------------------------------------------------------------------------
// Form data pair parser
// Path: an accepted byte is written into the queue; the back end then steps
// on it and registers its result. Throughput: one byte per cycle while the
// queue has room and results are taken; a queue write and a state machine step.
// Reset: synchronous, active high; limits return to 64 keys and 4096 bytes,
// the parser returns to key mode with all counters and the key cleared.
// ----------------------------------------------------------------------------
// Streaming url-encoded form decoder. The front end classifies each byte and
// queues it; the back end runs the key/value state machine and drives one
// registered result, so each side can stall independently of the other.
// ----------------------------------------------------------------------------
module form_data_pair_parser (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   // results
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_item_kind,
   output logic [7:0]  rsp_value_byte,
   output logic [63:0] rsp_packed_key,
   output logic [7:0]  rsp_pair_index,
   // configuration writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   fdp_pkg::cfg_type   cfg_ff, cfg_in;
   logic               q_valid;
   logic               q_pop;
   fdp_pkg::class_type q_head;

   // Limits take writes at any time; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            fdp_pkg::CSR_MAX_KEYS:  cfg_in.max_keys  = csr_wdata[8:0];
            fdp_pkg::CSR_MAX_BYTES: cfg_in.max_bytes = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_keys  <= 9'd64;
         cfg_ff.max_bytes <= 16'd4096;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: classify and queue each accepted item.
   fdp_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data_byte (req_data_byte),
      .q_valid       (q_valid),
      .q_head        (q_head),
      .q_pop         (q_pop)
   );

   // Back: advance the parser whenever the result register can take a result.
   fdp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg_ff),
      .q_valid        (q_valid),
      .q_head         (q_head),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_value_byte (rsp_value_byte),
      .rsp_packed_key (rsp_packed_key),
      .rsp_pair_index (rsp_pair_index)
   );

endmodule

/* tb/form_pair_checker.sv */
// ----------------------------------------------------------------------------
// Form pair checker
// Watches the byte, result and register channels of the form data pair
// parser, decodes every accepted byte on its own copy of the parser state and
// compares each accepted result, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module form_pair_checker
   import fdp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [1:0]  rsp_item_kind,
   input  logic [7:0]  rsp_value_byte,
   input  logic [63:0] rsp_packed_key,
   input  logic [7:0]  rsp_pair_index,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatches,
   output int          awaited
);

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  value;
      logic [63:0] key;
      logic [7:0]  index;
   } token_type;

   token_type   token_q [$];

   logic [8:0]  lim_keys;
   logic [15:0] lim_bytes;
   mode_type    mode;
   logic [63:0] key_acc;
   logic [3:0]  key_pos;
   logic [3:0]  hi_nib;
   logic [8:0]  pairs;
   logic [15:0] nbytes;

   initial mismatches = 0;
   initial awaited = 0;

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [3:0] v;
      v = 4'd0;
      if (c >= "0" && c <= "9") begin
         v = 4'(c - "0");
      end else if (c >= "a" && c <= "f") begin
         v = 4'(c - "a" + 8'd10);
      end else if (c >= "A" && c <= "F") begin
         v = 4'(c - "A" + 8'd10);
      end
      return v;
   endfunction

   task automatic clear_record();
      mode    = MODE_KEY;
      key_acc = '0;
      key_pos = '0;
      hi_nib  = '0;
      pairs   = '0;
      nbytes  = '0;
   endtask

   // End the current pair, or reject the record at the key limit
   task automatic close_pair(output token_type t);
      logic [8:0] next_count;
      next_count = pairs + 9'd1;
      t = '0;
      if (next_count >= lim_keys) begin
         t.kind = KIND_ERROR;
         mode = MODE_SKIP;
      end else begin
         t.kind  = KIND_PAIR;
         t.key   = key_acc;
         t.index = pairs[7:0];
         pairs   = next_count;
         mode    = MODE_KEY;
         key_acc = '0;
         key_pos = '0;
      end
   endtask

   task automatic parse_byte(input logic [7:0] c, output bit emits, output token_type t);
      emits = 1'b0;
      t = '0;
      if (c == 8'h00) begin
         if (mode == MODE_VALUE || mode == MODE_HEX1 || mode == MODE_HEX2) begin
            close_pair(t);
            emits = 1'b1;
         end
         clear_record();
      end else if (mode != MODE_SKIP) begin
         if (nbytes >= lim_bytes) begin
            t.kind = KIND_ERROR;
            emits = 1'b1;
            mode = MODE_SKIP;
         end else begin
            nbytes = nbytes + 16'd1;
            case (mode)
               MODE_KEY: begin
                  if (c == CHAR_EQUALS) begin
                     key_pos = 4'(KeyBytes);
                     mode = MODE_VALUE;
                  end else if (key_pos < KeyBytes) begin
                     key_acc = key_acc | (64'(c) << (8 * key_pos));
                     key_pos = key_pos + 4'd1;
                  end
               end
               MODE_VALUE: begin
                  if (c == CHAR_SEMI || c == CHAR_AMP) begin
                     close_pair(t);
                     emits = 1'b1;
                  end else if (c == CHAR_PERCENT) begin
                     mode = MODE_HEX1;
                  end else begin
                     t.kind = KIND_BYTE;
                     t.value = (c == CHAR_PLUS) ? CHAR_SPACE : c;
                     emits = 1'b1;
                  end
               end
               MODE_HEX1: begin
                  hi_nib = nibble_of(c);
                  mode = MODE_HEX2;
               end
               MODE_HEX2: begin
                  t.kind = KIND_BYTE;
                  t.value = {hi_nib, nibble_of(c)};
                  emits = 1'b1;
                  hi_nib = '0;
                  mode = MODE_VALUE;
               end
               default: ;
            endcase
         end
      end
   endtask

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      token_type due;
      token_type fresh;
      bit        emits;
      if (reset) begin
         lim_keys  = 9'd64;
         lim_bytes = 16'd4096;
         clear_record();
         token_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MAX_KEYS:  lim_keys = csr_wdata[8:0];
               CSR_MAX_BYTES: lim_bytes = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data_byte, emits, fresh);
            if (emits) begin
               token_q.push_back(fresh);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               report("result with nothing due, kind", 64'(rsp_item_kind), 64'd0);
            end else begin
               due = token_q.pop_front();
               if (rsp_item_kind !== due.kind)
                  report("item_kind", 64'(rsp_item_kind), 64'(due.kind));
               if (rsp_value_byte !== due.value)
                  report("value_byte", 64'(rsp_value_byte), 64'(due.value));
               if (rsp_packed_key !== due.key)
                  report("packed_key", rsp_packed_key, due.key);
               if (rsp_pair_index !== due.index)
                  report("pair_index", 64'(rsp_pair_index), 64'(due.index));
            end
         end
      end
      awaited <= token_q.size();
   end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Form data pair parser testbench
// Feeds url-encoded form records into the parser byte by byte: a short
// directed opening, then mostly well-formed random records under several
// limit settings, with random idling on both channels. The checker beside the
// parser predicts and compares; this top only makes stimulus and decides.
// ----------------------------------------------------------------------------
module testbench;
   import fdp_pkg::*;

   // Record terminator and a register index that maps to nothing
   localparam logic [7:0] END_OF_RECORD = 8'h00;
   localparam logic [1:0] CSR_UNUSED    = 2'd3;

   logic        clock;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [1:0]  rsp_item_kind;
   logic [7:0]  rsp_value_byte;
   logic [63:0] rsp_packed_key;
   logic [7:0]  rsp_pair_index;
   logic        csr_valid     = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index     = CSR_MAX_KEYS;
   logic [15:0] csr_wdata     = 16'h0000;

   int          mismatches;
   int          awaited;
   int          fed = 0;       // bytes accepted so far
   bit          calm = 1'b0;   // when set, neither side idles

   form_data_pair_parser dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_value_byte (rsp_value_byte),
      .rsp_packed_key (rsp_packed_key),
      .rsp_pair_index (rsp_pair_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   form_pair_checker pair_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_value_byte (rsp_value_byte),
      .rsp_packed_key (rsp_packed_key),
      .rsp_pair_index (rsp_pair_index),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatches     (mismatches),
      .awaited        (awaited)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop: far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // Offer one byte and return at the rising edge that takes it. Valid is left
   // high on return; the next call either drops it for an idle gap or keeps it
   // up with the new byte, so valid is assigned once per falling edge.
   task automatic feed_byte(input logic [7:0] b);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      fed++;
   endtask

   task automatic feed_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         feed_byte(s[i]);
      end
   endtask

   // Drop valid after the last byte of a burst
   task automatic stop_feed();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Hold until every predicted result is out, then let bytes that give no
   // result clear the parser's queue
   task automatic drain();
      while (awaited != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [7:0] hex_char();
      logic [3:0] d;
      d = 4'($urandom_range(0, 15));
      if (d < 4'd10) return 8'h30 + 8'(d);
      return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(d) - 8'd10;
   endfunction

   // Any nonzero byte except '='; half of them plain lowercase letters
   function automatic logic [7:0] key_char();
      logic [7:0] c;
      c = $urandom_range(0, 1) ? 8'($urandom_range(8'h61, 8'h7A)) : 8'($urandom_range(1, 255));
      if (c == CHAR_EQUALS) c = 8'h6B;
      return c;
   endfunction

   // Any nonzero byte that the value state passes straight through (or '+')
   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      c = 8'($urandom_range(1, 255));
      if (c == CHAR_SEMI || c == CHAR_AMP || c == CHAR_PERCENT) c = 8'h5F;
      return c;
   endfunction

   task automatic feed_key();
      repeat ($urandom_range(0, 10)) feed_byte(key_char());
   endtask

   task automatic feed_value();
      int pick;
      repeat ($urandom_range(0, 8)) begin
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            feed_byte(plain_char());
         end else if (pick < 75) begin
            feed_byte(CHAR_PLUS);
         end else if (pick < 95) begin
            feed_byte(CHAR_PERCENT);
            feed_byte(hex_char());
            feed_byte(hex_char());
         end else begin
            // malformed escape: any nonzero byte counts as a digit
            feed_byte(CHAR_PERCENT);
            feed_byte(8'($urandom_range(1, 255)));
            feed_byte(8'($urandom_range(1, 255)));
         end
      end
   endtask

   // One record: mostly well-formed pairs, some cut short, a few pure noise
   task automatic feed_record();
      int shape;
      int pairs;
      shape = $urandom_range(0, 99);
      calm = ($urandom_range(0, 4) == 0);
      if (shape < 75) begin
         pairs = $urandom_range(0, 6);
         for (int p = 0; p < pairs; p++) begin
            feed_key();
            feed_byte(CHAR_EQUALS);
            feed_value();
            // separate pairs; sometimes trail a separator before the end
            if (p < pairs - 1 || $urandom_range(0, 3) == 0) begin
               feed_byte($urandom_range(0, 1) ? CHAR_SEMI : CHAR_AMP);
            end
         end
      end else if (shape < 90) begin
         // key never closed by '=', or a value ending inside an escape
         feed_key();
         if ($urandom_range(0, 1)) begin
            feed_byte(CHAR_EQUALS);
            feed_value();
            feed_byte(CHAR_PERCENT);
            if ($urandom_range(0, 1)) feed_byte(hex_char());
         end
      end else begin
         repeat ($urandom_range(1, 20)) begin
            feed_byte(($urandom_range(0, 9) == 0) ? END_OF_RECORD
                                                  : 8'($urandom_range(1, 255)));
         end
      end
      feed_byte(END_OF_RECORD);
   endtask

   // Go idle, set both limits, then stream records until about the given number of bytes is taken
   task automatic run_phase(input logic [8:0] keys, input logic [15:0] bytes_lim,
                            input int count);
      int start;
      stop_feed();
      drain();
      write_reg(CSR_MAX_KEYS, 16'(keys));
      write_reg(CSR_MAX_BYTES, bytes_lim);
      start = fed;
      while (fed - start < count) feed_record();
   endtask

   // Result side: stall a random number of cycles before each item, never in
   // calm stretches
   initial begin
      int stall;
      wait (!reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 15);
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: nine key bytes (the ninth dropped), top byte, '+', a hex
      // escape, a non-hex digit and a separator taken as escape digits, then
      // a pair end
      feed_text("ABCDEFGHI=");
      feed_byte(8'hFF);
      feed_text("+%4a%g;;");
      // separators stored as key bytes; record ends inside an escape
      feed_text("x;&+%=%A");
      feed_byte(END_OF_RECORD);
      // record that ends while still in the key, then an empty record
      feed_byte("k");
      feed_byte(END_OF_RECORD);
      feed_byte(END_OF_RECORD);

      // Hold the sender until every result has come out
      stop_feed();
      drain();

      // Reset limits first
      while (fed < 130) feed_record();

      // Every pair end hits the key limit; then the second byte of every record hits
      // the byte limit; then both tight
      run_phase(9'd1, 16'hFFFF, 100);
      run_phase(9'd256, 16'd1, 80);
      run_phase(9'd3, 16'd24, 120);

      // Widest limits; a write to an unused index must change nothing. One
      // long record of empty pairs runs the pair index up to the key limit.
      run_phase(9'd256, 16'hFFFF, 0);
      write_reg(CSR_UNUSED, 16'hFFFF);
      calm = 1'b1;
      for (int p = 0; p < 260; p++) begin
         if (p == 100) calm = 1'b0;
         feed_byte(CHAR_EQUALS);
         feed_byte($urandom_range(0, 1) ? CHAR_SEMI : CHAR_AMP);
      end
      feed_byte(END_OF_RECORD);

      // Random limits, small byte limits more often than large ones
      for (int k = 0; k < 3; k++) begin
         run_phase(9'($urandom_range(1, 256)),
                   $urandom_range(0, 1) ? 16'($urandom_range(1, 40))
                                        : 16'($urandom_range(1, 65535)),
                   100);
      end

      stop_feed();
      drain();
      if (mismatches == 0 && awaited == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
